@@ rtl/tgarle_pkg.sv @@
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types and constants for the TGA run-length pixel decoder.
// ----------------------------------------------------------------------------
package tgarle_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_BPP    = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned BppW   = 3;
  localparam int unsigned DimW   = 16;
  localparam int unsigned PixelW = 32;
  localparam int unsigned CountW = 8;
  localparam int unsigned TotalW = 2 * DimW;

  // Packet header layout
  localparam int unsigned RunFlagBit = 7;
  localparam logic [6:0]  CountMask  = 7'h7F;

  // Register reset values
  localparam logic [BppW-1:0] BppReset    = 3'd4;
  localparam logic [DimW-1:0] WidthReset  = 16'd1;
  localparam logic [DimW-1:0] HeightReset = 16'd1;

  // Bytes per pixel as used: zero acts as one, above four acts as four
  function automatic logic [BppW-1:0] eff_bpp(input logic [BppW-1:0] bpp);
    logic [BppW-1:0] r;
    case (bpp)
      3'd0:    r = 3'd1;
      3'd1:    r = 3'd1;
      3'd2:    r = 3'd2;
      3'd3:    r = 3'd3;
      3'd4:    r = 3'd4;
      default: r = 3'd4;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/tga_rle_pixel_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_unit
// Decodes a TGA run-length stream, one byte per cycle, into pixels with
// repeat counts; flags the last pixel of each width-by-height image.
// ----------------------------------------------------------------------------
// A pixel completed by a byte transfer is on the output register in the next cycle.
// Throughput: one byte per cycle; the stream stalls while a pixel waits unaccepted.
// After a configuration write the input stalls while the registered
// width-times-height product settles.
// Reset (rst_ni low, asynchronous): waits for a packet header, registers go
// to bytes_per_pixel 4, width 1, height 1, and the output is empty.
module tga_rle_pixel_decoder_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [tgarle_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [tgarle_pkg::CfgDataW-1:0]     cfg_data_i,
  // input byte stream
  input  logic                                stream_byte_valid_i,
  output logic                                stream_byte_ready_o,
  input  logic [tgarle_pkg::ByteW-1:0]        stream_byte_i,
  // output pixels
  output logic                                pixel_valid_o,
  input  logic                                pixel_ready_i,
  output logic [tgarle_pkg::PixelW-1:0]       pixel_value_o,
  output logic [tgarle_pkg::CountW-1:0]       repeat_count_o,
  output logic                                image_done_o
);

  localparam int unsigned TotalW = tgarle_pkg::TotalW;
  localparam int unsigned CountW = tgarle_pkg::CountW;
  localparam int unsigned PixelW = tgarle_pkg::PixelW;

  // Configuration registers
  logic [tgarle_pkg::BppW-1:0] bpp_q;
  logic [tgarle_pkg::DimW-1:0] width_q, height_q;
  logic [TotalW-1:0]           total_q;
  logic                        settle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q    <= tgarle_pkg::BppReset;
      width_q  <= tgarle_pkg::WidthReset;
      height_q <= tgarle_pkg::HeightReset;
      settle_q <= 1'b0;
    end else begin
      settle_q <= cfg_we_i;
      if (cfg_we_i) begin
        case (cfg_index_i)
          tgarle_pkg::CFG_BPP:    bpp_q    <= cfg_data_i[tgarle_pkg::BppW-1:0];
          tgarle_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[tgarle_pkg::DimW-1:0];
          tgarle_pkg::CFG_HEIGHT: height_q <= cfg_data_i[tgarle_pkg::DimW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Image size product, registered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TotalW'(1);
    end else begin
      total_q <= TotalW'(width_q) * TotalW'(height_q);
    end
  end

  // Decoder state
  logic               expect_hdr_q;
  logic               run_q;
  logic [CountW-1:0]  remain_q;
  logic [1:0]         pos_q;
  logic [PixelW-1:0]  pixel_q;
  logic [TotalW-1:0]  emitted_q;

  // Output register
  logic               out_valid_q;
  logic [PixelW-1:0]  out_pixel_q;
  logic [CountW-1:0]  out_count_q;
  logic               out_done_q;

  logic in_fire;
  assign stream_byte_ready_o = !settle_q && (!out_valid_q || pixel_ready_i);
  assign in_fire = stream_byte_valid_i && stream_byte_ready_o;

  // Pixel assembly and packet bookkeeping
  logic [tgarle_pkg::BppW-1:0] eff_bpp;
  logic [PixelW-1:0]           pixel_next;
  logic                        last_byte;
  logic [TotalW-1:0]           left_raw, left;
  logic [CountW-1:0]           run_len, run_clip, count;
  logic                        left_small, done;
  logic [CountW-1:0]           remain_after;
  logic                        emit;

  always_comb begin
    eff_bpp    = tgarle_pkg::eff_bpp(bpp_q);
    pixel_next = pixel_q | (PixelW'(stream_byte_i) << {pos_q, 3'b000});
    last_byte  = ({1'b0, pos_q} + 3'd1) >= eff_bpp;

    // pixels still missing from the image, at least one
    left_raw = (emitted_q < total_q) ? (total_q - emitted_q) : '0;
    left     = (left_raw == '0) ? TotalW'(1) : left_raw;

    // run length clipped to the image
    run_len    = (remain_q == '0) ? CountW'(1) : remain_q;
    left_small = (left[TotalW-1:CountW] == '0);
    run_clip   = (left_small && (left[CountW-1:0] < run_len)) ? left[CountW-1:0] : run_len;

    count = run_q ? run_clip : CountW'(1);
    done  = (TotalW'(count) >= left);

    if (run_q) begin
      remain_after = '0;
    end else begin
      remain_after = (remain_q != '0) ? remain_q - CountW'(1) : '0;
    end

    emit = in_fire && !expect_hdr_q && last_byte;
  end

  // State update per byte transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_hdr_q <= 1'b1;
      run_q        <= 1'b0;
      remain_q     <= '0;
      pos_q        <= '0;
      pixel_q      <= '0;
      emitted_q    <= '0;
    end else if (in_fire) begin
      if (expect_hdr_q) begin
        // packet header: run flag and length of 1 to 128
        run_q        <= stream_byte_i[tgarle_pkg::RunFlagBit];
        remain_q     <= {1'b0, stream_byte_i[6:0] & tgarle_pkg::CountMask} + CountW'(1);
        pos_q        <= '0;
        pixel_q      <= '0;
        expect_hdr_q <= 1'b0;
      end else if (!last_byte) begin
        pixel_q <= pixel_next;
        pos_q   <= pos_q + 2'd1;
      end else begin
        // whole pixel assembled
        pixel_q   <= '0;
        pos_q     <= '0;
        emitted_q <= done ? '0 : emitted_q + TotalW'(count);
        if (done || (remain_after == '0)) begin
          expect_hdr_q <= 1'b1;
          remain_q     <= '0;
        end else begin
          remain_q <= remain_after;
        end
      end
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (pixel_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_pixel_q <= pixel_next;
      out_count_q <= count;
      out_done_q  <= done;
    end
  end

  assign pixel_valid_o  = out_valid_q;
  assign pixel_value_o  = out_pixel_q;
  assign repeat_count_o = out_count_q;
  assign image_done_o   = out_done_q;

endmodule

@@ dv/tb_tga_rle_pixel_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// tb_tga_rle_pixel_decoder_unit
// Self-checking bench for the TGA run-length pixel decoder. A directed table
// covers the packet types, the register extremes, run clipping and images
// that end inside a packet. Random images of varied size and pixel width
// follow. Every pixel transfer is checked against a typed table entry or an
// in-bench decoder model, with random idling on both the stream and the pixel side.
// ----------------------------------------------------------------------------
module tb_tga_rle_pixel_decoder_unit;
  import tgarle_pkg::*;

  // Index past the last register: a write there must be ignored
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
  localparam int unsigned RandBytes = 1525;
  localparam int unsigned HoldCycles = 300;

  typedef struct packed {
    logic [PixelW-1:0] value;
    logic [CountW-1:0] count;
    logic              done;
  } pixel_t;

  localparam pixel_t NoPixel = '0;

  // One directed step: a register write or a stream byte
  typedef struct packed {
    logic                is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    logic                typed;
    pixel_t              want;
  } step_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = CFG_BPP;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                stream_byte_valid_i = 1'b0;
  logic                stream_byte_ready_o;
  logic [ByteW-1:0]    stream_byte_i = '0;
  logic                pixel_valid_o;
  logic                pixel_ready_i = 1'b0;
  logic [PixelW-1:0]   pixel_value_o;
  logic [CountW-1:0]   repeat_count_o;
  logic                image_done_o;

  tga_rle_pixel_decoder_unit dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Decoder model: registers and stream state
  logic [BppW-1:0]   cur_bpp;
  logic [DimW-1:0]   cur_width;
  logic [DimW-1:0]   cur_height;
  logic              await_header;
  logic              run_mode;
  logic [7:0]        pkt_left;
  logic [1:0]        byte_pos;
  logic [PixelW-1:0] assembly;
  logic [31:0]       emitted;

  pixel_t      expected_pixels[$];
  int unsigned errors = 0;
  int unsigned hold_request = 0;
  int unsigned src_mode = 2;

  step_row_t dir_table [36] = '{
    // one-pixel image at reset settings, four bytes per pixel
    '{1'b0, RegUnused, 16'h0000, 1'b0, NoPixel},
    '{1'b0, RegUnused, 16'h0011, 1'b0, NoPixel},
    '{1'b0, RegUnused, 16'h0022, 1'b0, NoPixel},
    '{1'b0, RegUnused, 16'h0033, 1'b0, NoPixel},
    '{1'b0, RegUnused, 16'h0044, 1'b1, '{32'h44332211, 8'd1, 1'b1}},
    // largest image, longest run, then a raw packet of two
    '{1'b1, CFG_BPP,    16'h0001, 1'b0, NoPixel},
    '{1'b1, CFG_WIDTH,  16'hFFFF, 1'b0, NoPixel},
    '{1'b1, CFG_HEIGHT, 16'hFFFF, 1'b0, NoPixel},
    '{1'b0, RegUnused, 16'h00FF, 1'b0, NoPixel},
    '{1'b0, RegUnused, 16'h00FF, 1'b1, '{32'h000000FF, 8'd128, 1'b0}},
    '{1'b0, RegUnused, 16'h0001, 1'b0, NoPixel},
    '{1'b0, RegUnused, 16'h0000, 1'b1, '{32'h00000000, 8'd1, 1'b0}},
    '{1'b0, RegUnused, 16'h0080, 1'b1, '{32'h00000080, 8'd1, 1'b0}},
    // zero bytes per pixel acts as one; zero width ends every pixel
    '{1'b1, CFG_BPP,    16'h0000, 1'b0, NoPixel},
    '{1'b1, CFG_WIDTH,  16'h0000, 1'b0, NoPixel},
    '{1'b0, RegUnused, 16'h0080, 1'b0, NoPixel},
    '{1'b0, RegUnused, 16'h005A, 1'b1, '{32'h0000005A, 8'd1, 1'b1}},
    // seven acts as four; run of six clipped to a three-pixel image
    '{1'b1, CFG_BPP,    16'h0007, 1'b0, NoPixel},
    '{1'b1, CFG_WIDTH,  16'h0003, 1'b0, NoPixel},
    '{1'b1, CFG_HEIGHT, 16'h0001, 1'b0, NoPixel},
    '{1'b0, RegUnused, 16'h0085, 1'b0, NoPixel},
    '{1'b0, RegUnused, 16'h00A5, 1'b0, NoPixel},
    '{1'b0, RegUnused, 16'h005A, 1'b0, NoPixel},
    '{1'b0, RegUnused, 16'h00C3, 1'b0, NoPixel},
    '{1'b0, RegUnused, 16'h003C, 1'b1, '{32'h3CC35AA5, 8'd3, 1'b1}},
    // write past the last register, then an image ending inside a raw packet
    '{1'b1, RegUnused,  16'hFFFF, 1'b0, NoPixel},
    '{1'b1, CFG_BPP,    16'h0002, 1'b0, NoPixel},
    '{1'b1, CFG_WIDTH,  16'h0002, 1'b0, NoPixel},
    '{1'b0, RegUnused, 16'h0003, 1'b0, NoPixel},
    '{1'b0, RegUnused, 16'h0001, 1'b0, NoPixel},
    '{1'b0, RegUnused, 16'h0002, 1'b0, NoPixel},
    '{1'b0, RegUnused, 16'h0003, 1'b0, NoPixel},
    '{1'b0, RegUnused, 16'h0004, 1'b0, NoPixel},
    '{1'b0, RegUnused, 16'h0080, 1'b0, NoPixel},
    '{1'b0, RegUnused, 16'h0010, 1'b0, NoPixel},
    '{1'b0, RegUnused, 16'h0020, 1'b0, NoPixel}
  };

  // Idle wait before each item: none, occasional, or drawn uniformly at random
  function automatic int unsigned draw_wait(input int unsigned mode);
    int unsigned w;
    case (mode)
      0:       w = 0;
      1:       w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
      default: w = $urandom_range(0, 17);
    endcase
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // Model of one stream byte; emits at most one pixel
  task automatic decode_byte(input logic [ByteW-1:0] b, output logic emit,
                             output pixel_t res);
    logic [BppW-1:0] bpp_eff;
    logic [31:0]     total;
    logic [31:0]     left;
    logic [31:0]     cnt;
    emit = 1'b0;
    res = '0;
    bpp_eff = (cur_bpp == 3'd0) ? 3'd1 : (cur_bpp > 3'd4) ? 3'd4 : cur_bpp;
    if (await_header) begin
      run_mode = b[RunFlagBit];
      pkt_left = {1'b0, b[6:0] & CountMask} + 8'd1;
      byte_pos = '0;
      assembly = '0;
      await_header = 1'b0;
    end else begin
      assembly[8*byte_pos +: 8] = b;
      if (32'(byte_pos) + 32'd1 < 32'(bpp_eff)) begin
        byte_pos = byte_pos + 2'd1;
      end else begin
        // whole pixel: clip against what the image still misses
        total = 32'(cur_width) * 32'(cur_height);
        left = (emitted < total) ? total - emitted : 32'd0;
        if (left == 32'd0) left = 32'd1;
        if (run_mode) begin
          cnt = (pkt_left == 8'd0) ? 32'd1 : 32'(pkt_left);
          if (cnt > left) cnt = left;
          pkt_left = '0;
        end else begin
          cnt = 32'd1;
          if (pkt_left != 8'd0) pkt_left = pkt_left - 8'd1;
        end
        res.value = assembly;
        res.count = cnt[7:0];
        res.done = (cnt >= left);
        emit = 1'b1;
        emitted = res.done ? 32'd0 : emitted + cnt;
        byte_pos = '0;
        assembly = '0;
        if (res.done || pkt_left == 8'd0) begin
          await_header = 1'b1;
          pkt_left = '0;
        end
      end
    end
  endtask

  // One byte transfer; valid stays up on return in case the next byte follows
  task automatic push_byte(input logic [ByteW-1:0] b, output logic emit,
                           output pixel_t res);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) src_mode = $urandom_range(0, 2);
    gap = draw_wait(src_mode);
    if (gap != 0) begin
      stream_byte_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    stream_byte_valid_i <= 1'b1;
    stream_byte_i <= b;
    do @(posedge clk_i); while (!stream_byte_ready_o);
    decode_byte(b, emit, res);
  endtask

  // Stop offering bytes and let every pending pixel come out
  task automatic settle_stream();
    stream_byte_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_BPP:    cur_bpp = val[BppW-1:0];
      CFG_WIDTH:  cur_width = val;
      CFG_HEIGHT: cur_height = val;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [DimW-1:0] pick_dim();
    logic [DimW-1:0] d;
    case ($urandom_range(0, 9))
      0:       d = '0;
      1:       d = 16'hFFFF;
      2:       d = 16'($urandom_range(0, 65535));
      default: d = 16'($urandom_range(1, 6));
    endcase
    return d;
  endfunction

  task automatic check_pixel();
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      report_mismatch("pixel with none expected", pixel_value_o, 32'd0);
    end else begin
      want = expected_pixels.pop_front();
      if (pixel_value_o !== want.value)
        report_mismatch("pixel_value", pixel_value_o, want.value);
      if (repeat_count_o !== want.count)
        report_mismatch("repeat_count", 32'(repeat_count_o), 32'(want.count));
      if (image_done_o !== want.done)
        report_mismatch("image_done", 32'(image_done_o), 32'(want.done));
    end
  endtask

  // Pixel side: random stalls, one long hold-off on request
  initial begin : pixel_sink
    int unsigned stall;
    int unsigned snk_mode;
    snk_mode = 2;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) snk_mode = $urandom_range(0, 2);
      stall = draw_wait(snk_mode);
      if (hold_request != 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      if (stall != 0) begin
        pixel_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      pixel_ready_i <= 1'b1;
      do @(posedge clk_i); while (!pixel_valid_o);
      check_pixel();
    end
  end

  initial begin : watchdog
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // Stimulus: directed table, then random images phase by phase
  initial begin : byte_source
    logic [ByteW-1:0] b;
    logic             emit;
    pixel_t           res;
    int unsigned      sent;
    int unsigned      phase;
    int unsigned      len;
    int unsigned      nwrites;

    cur_bpp = BppReset;
    cur_width = WidthReset;
    cur_height = HeightReset;
    await_header = 1'b1;
    run_mode = 1'b0;
    pkt_left = '0;
    byte_pos = '0;
    assembly = '0;
    emitted = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[i]) begin
      if (dir_table[i].is_cfg) begin
        settle_stream();
        write_reg(dir_table[i].idx, dir_table[i].data);
      end else begin
        push_byte(dir_table[i].data[ByteW-1:0], emit, res);
        if (dir_table[i].typed) expected_pixels.push_back(dir_table[i].want);
        else if (emit) expected_pixels.push_back(res);
      end
    end

    sent = 0;
    phase = 0;
    while (sent < RandBytes) begin
      // drained stream: new sizes may shrink below what this image emitted
      settle_stream();
      nwrites = $urandom_range(0, 3);
      repeat (nwrites) begin
        case ($urandom_range(0, 6))
          0, 1: write_reg(CFG_BPP, {13'($urandom_range(0, 8191)),
                                    ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                                                : 3'($urandom_range(1, 4))});
          2, 3: write_reg(CFG_WIDTH, pick_dim());
          4, 5: write_reg(CFG_HEIGHT, pick_dim());
          default: write_reg(RegUnused, 16'($urandom_range(0, 65535)));
        endcase
      end
      // pixel side holds off while the stream keeps coming
      if (phase == 2) hold_request = HoldCycles;
      len = $urandom_range(16, 96);
      repeat (len) begin
        if (await_header) begin
          b[7] = 1'($urandom_range(0, 1));
          b[6:0] = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                               : 7'($urandom_range(0, 5));
        end else begin
          b = 8'($urandom_range(0, 255));
        end
        push_byte(b, emit, res);
        if (emit) expected_pixels.push_back(res);
        sent++;
      end
      phase++;
    end

    settle_stream();
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/tgarle_pkg.sv
rtl/tga_rle_pixel_decoder_unit.sv
dv/tb_tga_rle_pixel_decoder_unit.sv
